// ===== rtl/vmbr_pkg.sv =====
// Shared types, register offsets and field layout for the virtio-mmio block register unit.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package vmbr_pkg;

    localparam int unsigned MAX_QUEUE_SIZE = 256;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OFF_W    = 12;
    localparam int unsigned QNUM_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // stream payload layout
    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 264;

    localparam int unsigned OUT_RDATA_LSB  = 0;
    localparam int unsigned OUT_FAULT_LSB  = 64;
    localparam int unsigned OUT_IRQ_BIT    = 66;
    localparam int unsigned OUT_NOTIFY_BIT = 67;
    localparam int unsigned OUT_READY_BIT  = 68;
    localparam int unsigned OUT_DESC_LSB   = 69;
    localparam int unsigned OUT_AVAIL_LSB  = 133;
    localparam int unsigned OUT_USED_LSB   = 197;
    localparam int unsigned OUT_USED_MSB   = 260;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_DONE  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_WIDTH  = 2'd1,
        FAULT_RDONLY = 2'd2,
        FAULT_RANGE  = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        WIDTH_BYTE  = 2'd0,
        WIDTH_HALF  = 2'd1,
        WIDTH_WORD  = 2'd2,
        WIDTH_DWORD = 2'd3
    } t_width;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VENDOR   = 1'b1;

    localparam logic [OFF_W-1:0] OFF_MAGIC        = 12'h000;
    localparam logic [OFF_W-1:0] OFF_VERSION      = 12'h004;
    localparam logic [OFF_W-1:0] OFF_DEVICE_ID    = 12'h008;
    localparam logic [OFF_W-1:0] OFF_VENDOR_ID    = 12'h00c;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT     = 12'h010;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT_SEL = 12'h014;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT     = 12'h020;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT_SEL = 12'h024;
    localparam logic [OFF_W-1:0] OFF_PAGE_SIZE    = 12'h028;
    localparam logic [OFF_W-1:0] OFF_QUEUE_SEL    = 12'h030;
    localparam logic [OFF_W-1:0] OFF_QUEUE_MAX    = 12'h034;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NUM    = 12'h038;
    localparam logic [OFF_W-1:0] OFF_QUEUE_ALIGN  = 12'h03c;
    localparam logic [OFF_W-1:0] OFF_QUEUE_PFN    = 12'h040;
    localparam logic [OFF_W-1:0] OFF_NOTIFY       = 12'h050;
    localparam logic [OFF_W-1:0] OFF_IRQ_STATUS   = 12'h060;
    localparam logic [OFF_W-1:0] OFF_IRQ_ACK      = 12'h064;
    localparam logic [OFF_W-1:0] OFF_STATUS       = 12'h070;
    localparam logic [OFF_W-1:0] OFF_CONFIG       = 12'h100;

    localparam logic [WORD_W-1:0] MAGIC_WORD      = 32'h7472_6976;
    localparam logic [WORD_W-1:0] MMIO_VERSION    = 32'd1;
    localparam logic [WORD_W-1:0] DEV_ID_BLOCK    = 32'd2;
    localparam logic [WORD_W-1:0] RING_ALIGN_RST  = 32'd4096;

    // queue 0 settings after a step, handed to the address stage
    typedef struct packed {
        logic              ready;
        logic [WORD_W-1:0] page_frame;
        logic [WORD_W-1:0] page_bytes;
        logic [QNUM_W-1:0] entries;
        logic [WORD_W-1:0] align;
    } t_queue_cfg;

endpackage

`default_nettype wire

// ===== rtl/vmbr_regs.sv =====
// Transport register file: decodes one bus event, updates the register state, forms read data.
// Depends on vmbr_pkg.
`default_nettype none

module vmbr_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [vmbr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [vmbr_pkg::DATA_W-1:0]           i_cfg_data,
    input  wire logic                                  i_step,
    input  wire vmbr_pkg::t_req                        i_req,
    input  wire logic [vmbr_pkg::OFF_W-1:0]            i_offset,
    input  wire vmbr_pkg::t_width                      i_width,
    input  wire logic [vmbr_pkg::WORD_W-1:0]           i_wdata,
    output logic [vmbr_pkg::DATA_W-1:0]                o_read_data,
    output vmbr_pkg::t_fault                           o_fault,
    output logic                                       o_irq,
    output logic                                       o_notify,
    output vmbr_pkg::t_queue_cfg                       o_queue
);

    logic [vmbr_pkg::DATA_W-1:0] r_capacity;
    logic [vmbr_pkg::WORD_W-1:0] r_vendor;

    logic [vmbr_pkg::WORD_W-1:0] r_dev_feat_sel, n_dev_feat_sel;
    logic [vmbr_pkg::WORD_W-1:0] r_drv_feat_sel, n_drv_feat_sel;
    logic [vmbr_pkg::WORD_W-1:0] r_drv_feat,     n_drv_feat;
    logic [vmbr_pkg::WORD_W-1:0] r_page_bytes,   n_page_bytes;
    logic [vmbr_pkg::WORD_W-1:0] r_queue_sel,    n_queue_sel;
    logic [vmbr_pkg::QNUM_W-1:0] r_queue_num,    n_queue_num;
    logic [vmbr_pkg::WORD_W-1:0] r_align,        n_align;
    logic [vmbr_pkg::WORD_W-1:0] r_pfn,          n_pfn;
    logic [7:0]                  r_irq_bits,     n_irq_bits;
    logic [7:0]                  r_status,       n_status;
    logic                        r_pending,      n_pending;

    logic                        is_cfg_space;
    logic                        bad_reg_access;
    logic [vmbr_pkg::OFF_W-1:0]  cfg_rel;
    logic [vmbr_pkg::OFF_W:0]    cfg_end;
    logic                        cfg_oob;
    logic [vmbr_pkg::DATA_W-1:0] cfg_shifted;
    logic [vmbr_pkg::DATA_W-1:0] cfg_value;
    logic [vmbr_pkg::WORD_W-1:0] reg_value;

    function automatic logic queue_ok(
        input logic [vmbr_pkg::WORD_W-1:0] sel,
        input logic [vmbr_pkg::WORD_W-1:0] bytes,
        input logic [vmbr_pkg::WORD_W-1:0] pfn,
        input logic [vmbr_pkg::QNUM_W-1:0] num,
        input logic [vmbr_pkg::WORD_W-1:0] align
    );
        logic num_p2;
        logic align_p2;
        num_p2   = (num != '0) && ((num & (num - 1'b1)) == '0);
        align_p2 = (align != '0) && ((align & (align - 1'b1)) == '0);
        return (sel == '0) && (bytes != '0) && (pfn != '0) && num_p2 && align_p2 &&
               ({16'b0, num} <= 32'(vmbr_pkg::MAX_QUEUE_SIZE));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_vendor   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vmbr_pkg::CFG_IDX_CAPACITY: r_capacity <= i_cfg_data;
                vmbr_pkg::CFG_IDX_VENDOR:   r_vendor   <= i_cfg_data[vmbr_pkg::WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // config space: 8 capacity bytes at any byte alignment
    always_comb begin
        is_cfg_space = (i_offset >= vmbr_pkg::OFF_CONFIG);
        bad_reg_access = (i_width != vmbr_pkg::WIDTH_WORD) || (i_offset[1:0] != 2'b00);
        cfg_rel     = i_offset - vmbr_pkg::OFF_CONFIG;
        cfg_end     = {1'b0, cfg_rel} + (13'd1 << i_width);
        cfg_oob     = (cfg_end > 13'd8);
        cfg_shifted = r_capacity >> {cfg_rel[2:0], 3'b000};
        case (i_width)
            vmbr_pkg::WIDTH_BYTE: cfg_value = 64'(cfg_shifted[7:0]);
            vmbr_pkg::WIDTH_HALF: cfg_value = 64'(cfg_shifted[15:0]);
            vmbr_pkg::WIDTH_WORD: cfg_value = 64'(cfg_shifted[31:0]);
            default:              cfg_value = cfg_shifted;
        endcase
    end

    always_comb begin
        unique case (i_offset)
            vmbr_pkg::OFF_MAGIC:      reg_value = vmbr_pkg::MAGIC_WORD;
            vmbr_pkg::OFF_VERSION:    reg_value = vmbr_pkg::MMIO_VERSION;
            vmbr_pkg::OFF_DEVICE_ID:  reg_value = vmbr_pkg::DEV_ID_BLOCK;
            vmbr_pkg::OFF_VENDOR_ID:  reg_value = r_vendor;
            vmbr_pkg::OFF_QUEUE_MAX:
                reg_value = (r_queue_sel == '0) ? 32'(vmbr_pkg::MAX_QUEUE_SIZE) : '0;
            vmbr_pkg::OFF_QUEUE_PFN:  reg_value = r_pfn;
            vmbr_pkg::OFF_IRQ_STATUS: reg_value = 32'(r_irq_bits);
            vmbr_pkg::OFF_STATUS:     reg_value = 32'(r_status);
            default:                  reg_value = '0;
        endcase
    end

    // read data and fault
    always_comb begin
        o_read_data = '0;
        o_fault     = vmbr_pkg::FAULT_NONE;
        if (i_req == vmbr_pkg::REQ_READ) begin
            if (is_cfg_space) begin
                if (cfg_oob) begin
                    o_fault = vmbr_pkg::FAULT_RANGE;
                end else begin
                    o_read_data = cfg_value;
                end
            end else if (bad_reg_access) begin
                o_fault = vmbr_pkg::FAULT_WIDTH;
            end else begin
                o_read_data = 64'(reg_value);
            end
        end else if (i_req == vmbr_pkg::REQ_WRITE) begin
            if (is_cfg_space) begin
                o_fault = vmbr_pkg::FAULT_RDONLY;
            end else if (bad_reg_access) begin
                o_fault = vmbr_pkg::FAULT_WIDTH;
            end
        end
    end

    // next state
    always_comb begin
        n_dev_feat_sel = r_dev_feat_sel;
        n_drv_feat_sel = r_drv_feat_sel;
        n_drv_feat     = r_drv_feat;
        n_page_bytes   = r_page_bytes;
        n_queue_sel    = r_queue_sel;
        n_queue_num    = r_queue_num;
        n_align        = r_align;
        n_pfn          = r_pfn;
        n_irq_bits     = r_irq_bits;
        n_status       = r_status;
        n_pending      = r_pending;
        if (i_req == vmbr_pkg::REQ_WRITE && !is_cfg_space && !bad_reg_access) begin
            unique case (i_offset)
                vmbr_pkg::OFF_DEV_FEAT_SEL: n_dev_feat_sel = i_wdata;
                vmbr_pkg::OFF_DRV_FEAT: begin
                    if (r_drv_feat_sel == '0) n_drv_feat = i_wdata;
                end
                vmbr_pkg::OFF_DRV_FEAT_SEL: n_drv_feat_sel = i_wdata;
                vmbr_pkg::OFF_PAGE_SIZE:    n_page_bytes   = i_wdata;
                vmbr_pkg::OFF_QUEUE_SEL:    n_queue_sel    = i_wdata;
                vmbr_pkg::OFF_QUEUE_NUM:    n_queue_num    = i_wdata[vmbr_pkg::QNUM_W-1:0];
                vmbr_pkg::OFF_QUEUE_ALIGN:  n_align        = i_wdata;
                vmbr_pkg::OFF_QUEUE_PFN:    n_pfn          = i_wdata;
                vmbr_pkg::OFF_NOTIFY: begin
                    if (i_wdata == '0 &&
                        queue_ok(r_queue_sel, r_page_bytes, r_pfn, r_queue_num, r_align)) begin
                        n_pending = 1'b1;
                    end
                end
                vmbr_pkg::OFF_IRQ_ACK:      n_irq_bits = r_irq_bits & ~i_wdata[7:0];
                vmbr_pkg::OFF_STATUS: begin
                    if (i_wdata == '0) begin
                        // transport reset, page size survives
                        n_dev_feat_sel = '0;
                        n_drv_feat_sel = '0;
                        n_drv_feat     = '0;
                        n_queue_sel    = '0;
                        n_queue_num    = '0;
                        n_align        = vmbr_pkg::RING_ALIGN_RST;
                        n_pfn          = '0;
                        n_irq_bits     = '0;
                        n_status       = '0;
                        n_pending      = 1'b0;
                    end else begin
                        n_status = i_wdata[7:0];
                    end
                end
                default: ;
            endcase
        end else if (i_req == vmbr_pkg::REQ_DONE) begin
            n_irq_bits[0] = 1'b1;
        end else if (i_req == vmbr_pkg::REQ_TICK) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_feat_sel <= '0;
            r_drv_feat_sel <= '0;
            r_drv_feat     <= '0;
            r_page_bytes   <= '0;
            r_queue_sel    <= '0;
            r_queue_num    <= '0;
            r_align        <= vmbr_pkg::RING_ALIGN_RST;
            r_pfn          <= '0;
            r_irq_bits     <= '0;
            r_status       <= '0;
            r_pending      <= 1'b0;
        end else if (i_step) begin
            r_dev_feat_sel <= n_dev_feat_sel;
            r_drv_feat_sel <= n_drv_feat_sel;
            r_drv_feat     <= n_drv_feat;
            r_page_bytes   <= n_page_bytes;
            r_queue_sel    <= n_queue_sel;
            r_queue_num    <= n_queue_num;
            r_align        <= n_align;
            r_pfn          <= n_pfn;
            r_irq_bits     <= n_irq_bits;
            r_status       <= n_status;
            r_pending      <= n_pending;
        end
    end

    // the tick reports the notify it clears
    assign o_notify = (i_req == vmbr_pkg::REQ_TICK) ? r_pending : n_pending;
    assign o_irq    = n_irq_bits[0];

    assign o_queue.ready      = queue_ok(n_queue_sel, n_page_bytes, n_pfn, n_queue_num, n_align);
    assign o_queue.page_frame = n_pfn;
    assign o_queue.page_bytes = n_page_bytes;
    assign o_queue.entries    = n_queue_num;
    assign o_queue.align      = n_align;

    // feature registers are write-only here; keep them observable to synthesis through nothing
    logic unused_feat;
    assign unused_feat = ^{r_dev_feat_sel, r_drv_feat};

endmodule

`default_nettype wire

// ===== rtl/vmbr_ring.sv =====
// Ring address stage: registers page_frame * page_bytes and the ring sizes, then forms the
// descriptor, available and used ring addresses. Depends on vmbr_pkg.
`default_nettype none

module vmbr_ring (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire vmbr_pkg::t_queue_cfg          i_queue,
    output logic                               o_ready,
    output logic [vmbr_pkg::DATA_W-1:0]        o_desc_addr,
    output logic [vmbr_pkg::DATA_W-1:0]        o_avail_addr,
    output logic [vmbr_pkg::DATA_W-1:0]        o_used_addr
);

    localparam int unsigned SPAN_W = vmbr_pkg::WORD_W + 1;

    logic                              r_ready;
    logic [vmbr_pkg::DATA_W-1:0]       r_prod;
    logic [vmbr_pkg::QNUM_W-1:0]       r_entries;
    logic [SPAN_W-1:0]                 r_span;      // 18*n + 4 + align - 1
    logic [vmbr_pkg::WORD_W-1:0]       r_align_m1;

    logic [SPAN_W-1:0]                 span;
    logic [vmbr_pkg::DATA_W-1:0]       avail;
    logic [vmbr_pkg::DATA_W-1:0]       used;

    always_comb begin
        span = SPAN_W'({i_queue.entries, 4'b0000}) + SPAN_W'({i_queue.entries, 1'b0})
             + SPAN_W'(4) + SPAN_W'(i_queue.align - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ready    <= i_queue.ready;
            r_prod     <= 64'(i_queue.page_frame) * 64'(i_queue.page_bytes);
            r_entries  <= i_queue.entries;
            r_span     <= span;
            r_align_m1 <= i_queue.align - 1'b1;
        end
    end

    always_comb begin
        avail = r_prod + 64'({r_entries, 4'b0000});
        used  = (r_prod + 64'(r_span)) & {32'hffff_ffff, ~r_align_m1};
    end

    assign o_ready      = r_ready;
    assign o_desc_addr  = r_ready ? r_prod : '0;
    assign o_avail_addr = r_ready ? avail  : '0;
    assign o_used_addr  = r_ready ? used   : '0;

endmodule

`default_nettype wire

// ===== rtl/virtio_mmio_block_registers_unit.sv =====
// Top level of the legacy virtio-mmio block register unit: input stage, register file,
// ring address stage and output register. Depends on vmbr_pkg, vmbr_regs, vmbr_ring.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: offset, width, write data
//                                                       tuser: request type
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: read data, fault, irq, notify,
//                                                       ready, desc, avail, used addresses
//   cfg       in         i_cfg_we                       i_cfg_index, i_cfg_data
//
// One item per cycle sustained while m_axis takes the output; each item passes three
// registers (input register, register update + product register, output register) and is
// offered on m_axis from the output register.
// Register state updates as the item leaves the input register, so back-to-back items see
// each other's writes. The pipeline stalls as a whole while the output item is not taken.
// Reset is synchronous, active low, and clears the valid bits and the transport registers.
`default_nettype none

module virtio_mmio_block_registers_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [vmbr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [vmbr_pkg::DATA_W-1:0]          i_cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [11:0] bus_offset, [13:12] access_width, [77:14] write_data, [79:78] zero
    input  wire logic [vmbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] req_type
    input  wire logic [vmbr_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [63:0] read_data, [65:64] fault_code, [66] irq_line, [67] notify_due,
    // [68] queue_ready, [132:69] desc_table_addr, [196:133] avail_ring_addr,
    // [260:197] used_ring_addr, [263:261] zero
    output logic [vmbr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    logic advance;

    logic                          r_s1_valid;
    vmbr_pkg::t_req                r_s1_req;
    logic [vmbr_pkg::OFF_W-1:0]    r_s1_offset;
    vmbr_pkg::t_width              r_s1_width;
    logic [vmbr_pkg::WORD_W-1:0]   r_s1_wdata;

    logic                          r_s2_valid;
    logic [vmbr_pkg::DATA_W-1:0]   r_s2_rdata;
    vmbr_pkg::t_fault              r_s2_fault;
    logic                          r_s2_irq;
    logic                          r_s2_notify;

    logic                          r_out_valid;
    logic [vmbr_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [vmbr_pkg::DATA_W-1:0]   rd_data;
    vmbr_pkg::t_fault              rd_fault;
    logic                          rd_irq;
    logic                          rd_notify;
    vmbr_pkg::t_queue_cfg          queue;

    logic                          ring_ready;
    logic [vmbr_pkg::DATA_W-1:0]   desc_addr;
    logic [vmbr_pkg::DATA_W-1:0]   avail_addr;
    logic [vmbr_pkg::DATA_W-1:0]   used_addr;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= s_axis_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && s_axis_tvalid) begin
            r_s1_req    <= vmbr_pkg::t_req'(s_axis_tuser[1:0]);
            r_s1_offset <= s_axis_tdata[11:0];
            r_s1_width  <= vmbr_pkg::t_width'(s_axis_tdata[13:12]);
            r_s1_wdata  <= s_axis_tdata[45:14];
        end
    end

    vmbr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (advance && r_s1_valid),
        .i_req       (r_s1_req),
        .i_offset    (r_s1_offset),
        .i_width     (r_s1_width),
        .i_wdata     (r_s1_wdata),
        .o_read_data (rd_data),
        .o_fault     (rd_fault),
        .o_irq       (rd_irq),
        .o_notify    (rd_notify),
        .o_queue     (queue)
    );

    vmbr_ring u_ring (
        .i_clk        (i_clk),
        .i_en         (advance),
        .i_queue      (queue),
        .o_ready      (ring_ready),
        .o_desc_addr  (desc_addr),
        .o_avail_addr (avail_addr),
        .o_used_addr  (used_addr)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_rdata  <= rd_data;
            r_s2_fault  <= rd_fault;
            r_s2_irq    <= rd_irq;
            r_s2_notify <= rd_notify;
            r_out_data  <= {3'b000, used_addr, avail_addr, desc_addr, ring_ready,
                            r_s2_notify, r_s2_irq, r_s2_fault, r_s2_rdata};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/vmbr_checker.sv =====
// Port-level checks for the virtio-mmio block register unit, bound to the top level.
// Depends on vmbr_pkg and virtio_mmio_block_registers_unit.
`default_nettype none

module vmbr_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [vmbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic q_ready;
    assign q_ready = m_axis_tdata[vmbr_pkg::OUT_READY_BIT];

    // held output item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // no item comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an unconfigured queue reports zero addresses
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !q_ready |->
            m_axis_tdata[vmbr_pkg::OUT_USED_MSB:vmbr_pkg::OUT_DESC_LSB] == '0)
        else $error("ring addresses nonzero without a ready queue");

    // a faulted access returns no data
    a_fault_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[vmbr_pkg::OUT_FAULT_LSB +: 2] != 2'b00 |->
            m_axis_tdata[vmbr_pkg::OUT_RDATA_LSB +: 64] == '0)
        else $error("read data on a faulted access");

    // a ready queue has at least one descriptor, so the available ring is past the table
    a_ring_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && q_ready |->
            m_axis_tdata[vmbr_pkg::OUT_AVAIL_LSB +: 64] !=
            m_axis_tdata[vmbr_pkg::OUT_DESC_LSB +: 64])
        else $error("available ring overlaps descriptor table start");

endmodule

bind virtio_mmio_block_registers_unit vmbr_checker u_vmbr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/virtio_mmio_block_registers_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for virtio_mmio_block_registers_unit: drives bus reads, writes, completions and
// ticks over the input stream, predicts every reply and checks it field by field.
// Depends on vmbr_pkg and the rtl top level only.

module virtio_mmio_block_registers_unit_tb;

    import vmbr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [63:0] rdata;
        t_fault      fault;
        logic        irq;
        logic        notify;
        logic        ready;
        logic [63:0] desc;
        logic [63:0] avail;
        logic [63:0] used;
    } t_reply;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [DATA_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [11:0] bus_offset, [13:12] access_width, [77:14] write_data, [79:78] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [1:0] req_type
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // [63:0] read_data, [65:64] fault_code, [66] irq_line, [67] notify_due,
    // [68] queue_ready, [132:69] desc, [196:133] avail, [260:197] used, [263:261] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // predicted device state
    logic [63:0] cfg_capacity   = '0;
    logic [31:0] cfg_vendor     = '0;
    logic [31:0] fsel_dev       = '0;
    logic [31:0] fsel_drv       = '0;
    logic [31:0] drv_features   = '0;
    logic [31:0] pg_size        = '0;
    logic [31:0] q_sel          = '0;
    logic [15:0] q_num          = '0;
    logic [31:0] q_align        = RING_ALIGN_RST;
    logic [31:0] q_pfn          = '0;
    logic [7:0]  irq_status     = '0;
    logic [7:0]  status_reg     = '0;
    logic        notify_pending = 1'b0;

    t_reply      bus_replies[$];
    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned source_steady = 0;
    int unsigned sink_hold     = 0;
    int unsigned sink_pick;
    logic        sink_level    = 1'b1;
    int unsigned stall_cycles  = 0;

    virtio_mmio_block_registers_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_pow2(logic [31:0] v);
        return v != '0 && (v & (v - 32'd1)) == '0;
    endfunction

    function automatic logic queue_live();
        return q_sel == '0 && pg_size != '0 && q_pfn != '0 && q_num != '0 &&
               q_num <= MAX_QUEUE_SIZE && is_pow2(32'(q_num)) && is_pow2(q_align);
    endfunction

    // applies one item to the predicted state and returns the reply it should produce
    function automatic t_reply predict_reply(t_req req, logic [11:0] off, t_width w,
                                             logic [63:0] data);
        t_reply      r;
        logic [31:0] word;
        logic [11:0] rel;
        int unsigned nbytes;
        logic [63:0] n;
        logic [63:0] al;
        r    = '0;
        word = data[31:0];
        case (req)
            REQ_READ: begin
                if (off >= OFF_CONFIG) begin
                    rel    = off - OFF_CONFIG;
                    nbytes = 1 << w;
                    if (rel > 8 || rel + nbytes > 8) begin
                        r.fault = FAULT_RANGE;
                    end else begin
                        r.rdata = cfg_capacity >> (8 * rel);
                        if (nbytes < 8)
                            r.rdata &= (64'd1 << (8 * nbytes)) - 64'd1;
                    end
                end else if (w != WIDTH_WORD || off[1:0] != 2'b00) begin
                    r.fault = FAULT_WIDTH;
                end else begin
                    case (off)
                        OFF_MAGIC:      r.rdata = MAGIC_WORD;
                        OFF_VERSION:    r.rdata = MMIO_VERSION;
                        OFF_DEVICE_ID:  r.rdata = DEV_ID_BLOCK;
                        OFF_VENDOR_ID:  r.rdata = cfg_vendor;
                        OFF_QUEUE_MAX:  r.rdata = (q_sel == '0) ? MAX_QUEUE_SIZE : 0;
                        OFF_QUEUE_PFN:  r.rdata = q_pfn;
                        OFF_IRQ_STATUS: r.rdata = irq_status;
                        OFF_STATUS:     r.rdata = status_reg;
                        default:        r.rdata = '0;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (off >= OFF_CONFIG) begin
                    r.fault = FAULT_RDONLY;
                end else if (w != WIDTH_WORD || off[1:0] != 2'b00) begin
                    r.fault = FAULT_WIDTH;
                end else begin
                    case (off)
                        OFF_DEV_FEAT_SEL: fsel_dev = word;
                        OFF_DRV_FEAT:     if (fsel_drv == '0) drv_features = word;
                        OFF_DRV_FEAT_SEL: fsel_drv = word;
                        OFF_PAGE_SIZE:    pg_size = word;
                        OFF_QUEUE_SEL:    q_sel = word;
                        OFF_QUEUE_NUM:    q_num = word[15:0];
                        OFF_QUEUE_ALIGN:  q_align = word;
                        OFF_QUEUE_PFN:    q_pfn = word;
                        OFF_NOTIFY:       if (word == '0 && queue_live()) notify_pending = 1'b1;
                        OFF_IRQ_ACK:      irq_status &= ~word[7:0];
                        OFF_STATUS: begin
                            // zero status resets the transport, page size survives
                            if (word == '0) begin
                                fsel_dev       = '0;
                                fsel_drv       = '0;
                                drv_features   = '0;
                                q_sel          = '0;
                                q_num          = '0;
                                q_align        = RING_ALIGN_RST;
                                q_pfn          = '0;
                                irq_status     = '0;
                                status_reg     = '0;
                                notify_pending = 1'b0;
                            end else begin
                                status_reg = word[7:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_DONE: irq_status[0] = 1'b1;
            default: ;
        endcase
        // a tick reports the pending notify before clearing it
        r.notify = notify_pending;
        if (req == REQ_TICK)
            notify_pending = 1'b0;
        r.irq   = irq_status[0];
        r.ready = queue_live();
        if (r.ready) begin
            n       = 64'(q_num);
            al      = 64'(q_align);
            r.desc  = 64'(q_pfn) * 64'(pg_size);
            r.avail = r.desc + (n << 4);
            r.used  = (r.avail + 64'd4 + (n << 1) + al - 64'd1) & ~(al - 64'd1);
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_data();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return '1;
            2:       return {32'($urandom), 32'($urandom_range(0, 15))};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [11:0] any_register();
        case ($urandom_range(0, 19))
            0:       return OFF_MAGIC;
            1:       return OFF_VERSION;
            2:       return OFF_DEVICE_ID;
            3:       return OFF_VENDOR_ID;
            4:       return OFF_DEV_FEAT;
            5:       return OFF_DEV_FEAT_SEL;
            6:       return OFF_DRV_FEAT;
            7:       return OFF_DRV_FEAT_SEL;
            8:       return OFF_PAGE_SIZE;
            9:       return OFF_QUEUE_SEL;
            10:      return OFF_QUEUE_MAX;
            11:      return OFF_QUEUE_NUM;
            12:      return OFF_QUEUE_ALIGN;
            13:      return OFF_QUEUE_PFN;
            14:      return OFF_NOTIFY;
            15:      return OFF_IRQ_STATUS;
            16:      return OFF_IRQ_ACK;
            17:      return OFF_STATUS;
            18:      return 12'h044;
            default: return 12'h0fc;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(t_req req, logic [11:0] off, t_width w, logic [63:0] data);
        int unsigned gap;
        int unsigned pick;
        t_reply      want;
        gap = 0;
        if (source_steady != 0) begin
            source_steady--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                source_steady = $urandom_range(30, 120);
            else if (pick < 60)
                gap = 0;
            else if (pick < 90)
                gap = $urandom_range(1, 3);
            else if (pick < 98)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 40);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, data, w, off};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = predict_reply(req, off, w, data);
        bus_replies.insert(bus_replies.size(), want);
        items_sent++;
    endtask

    task automatic rd(logic [11:0] off);
        send_item(REQ_READ, off, WIDTH_WORD, {32'($urandom), 32'($urandom)});
    endtask

    task automatic wr(logic [11:0] off, logic [31:0] word);
        send_item(REQ_WRITE, off, WIDTH_WORD, {32'($urandom), word});
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (bus_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [63:0] capacity, logic [31:0] vendor);
        wait_for_replies();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_CAPACITY;
        i_cfg_data  <= capacity;
        @(posedge i_clk);
        cfg_capacity = capacity;
        i_cfg_index <= CFG_IDX_VENDOR;
        i_cfg_data  <= {32'd0, vendor};
        @(posedge i_clk);
        cfg_vendor = vendor;
        i_cfg_we   <= 1'b0;
    endtask

    // one plausible driver action on a running device
    task automatic traffic_item();
        case ($urandom_range(0, 11))
            0, 1:    send_item(REQ_WRITE, OFF_NOTIFY, WIDTH_WORD,
                               ($urandom_range(0, 3) == 0) ? rand_data() : 64'd0);
            2:       send_item(REQ_DONE, 12'($urandom), t_width'($urandom_range(0, 3)),
                               {32'($urandom), 32'($urandom)});
            3:       send_item(REQ_TICK, 12'($urandom), t_width'($urandom_range(0, 3)),
                               {32'($urandom), 32'($urandom)});
            4:       rd(OFF_IRQ_STATUS);
            5:       send_item(REQ_WRITE, OFF_IRQ_ACK, WIDTH_WORD, rand_data());
            6, 7:    send_item(REQ_READ, OFF_CONFIG + 12'($urandom_range(0, 15)),
                               t_width'($urandom_range(0, 3)), {32'($urandom), 32'($urandom)});
            8:       rd(any_register());
            9:       send_item(REQ_WRITE, any_register(), WIDTH_WORD, rand_data());
            10:      wr(OFF_DRV_FEAT_SEL, ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom));
            default: wr(OFF_DRV_FEAT, $urandom);
        endcase
    endtask

    task automatic test_reset_values();
        rd(OFF_MAGIC);
        rd(OFF_VERSION);
        rd(OFF_DEVICE_ID);
        rd(OFF_VENDOR_ID);
        rd(OFF_QUEUE_MAX);
        send_item(REQ_READ, OFF_CONFIG, WIDTH_DWORD, '1);
    endtask

    task automatic test_access_faults();
        send_item(REQ_READ, 12'h107, WIDTH_BYTE, '0);     // last capacity byte
        send_item(REQ_READ, 12'h107, WIDTH_HALF, '0);     // runs past capacity
        send_item(REQ_READ, 12'h101, WIDTH_DWORD, '0);
        send_item(REQ_READ, 12'h108, WIDTH_BYTE, '0);
        send_item(REQ_READ, 12'hfff, WIDTH_DWORD, '1);
        send_item(REQ_READ, OFF_MAGIC, WIDTH_HALF, '0);
        send_item(REQ_READ, 12'h002, WIDTH_WORD, '0);
        send_item(REQ_WRITE, OFF_CONFIG, WIDTH_WORD, '1);
        send_item(REQ_WRITE, 12'hfff, WIDTH_BYTE, '1);
        send_item(REQ_WRITE, OFF_MAGIC, WIDTH_WORD, '1);  // read-only, dropped
    endtask

    task automatic test_queue_bringup();
        wr(OFF_STATUS, 32'h0000_000f);
        wr(OFF_PAGE_SIZE, 32'd4096);
        wr(OFF_QUEUE_NUM, 32'hffff_0100);                 // only the low half counts
        wr(OFF_QUEUE_PFN, 32'hffff_ffff);
        send_item(REQ_WRITE, OFF_NOTIFY, WIDTH_WORD, 64'h1);
        send_item(REQ_WRITE, OFF_NOTIFY, WIDTH_WORD, 64'hffff_ffff_0000_0000);
        send_item(REQ_DONE, '0, WIDTH_BYTE, '0);
        send_item(REQ_TICK, '1, WIDTH_DWORD, '1);
        send_item(REQ_WRITE, OFF_IRQ_ACK, WIDTH_WORD, '1);
        wr(OFF_STATUS, 32'd0);
    endtask

    // mostly complete queue setups followed by traffic, some loose accesses and noise
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 3) == 0)
                    wr(OFF_STATUS, 32'd0);
                wr(OFF_STATUS, $urandom_range(1, 255));
                wr(OFF_PAGE_SIZE, ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                              : 32'd1 << $urandom_range(0, 16));
                wr(OFF_QUEUE_SEL, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
                rd(OFF_QUEUE_MAX);
                wr(OFF_QUEUE_NUM, ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                  : {16'($urandom), 16'd1 << $urandom_range(0, 8)});
                wr(OFF_QUEUE_ALIGN, ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                                : 32'd1 << $urandom_range(0, 31));
                wr(OFF_QUEUE_PFN, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4)
                                                              : 32'($urandom));
                rd(OFF_QUEUE_PFN);
                repeat ($urandom_range(3, 20)) traffic_item();
            end else if (pick < 80) begin
                traffic_item();
            end else begin
                send_item(t_req'($urandom_range(0, 3)),
                          ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 255))
                                                      : 12'($urandom),
                          t_width'($urandom_range(0, 3)), {32'($urandom), 32'($urandom)});
            end
            if ($urandom_range(0, 99) == 0)
                wait_for_replies();
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold == 0) begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 10) begin
                sink_level = 1'b1;
                sink_hold  = $urandom_range(50, 200);
            end else if (sink_pick < 70) begin
                sink_level = 1'b1;
                sink_hold  = $urandom_range(1, 4);
            end else if (sink_pick < 96) begin
                sink_level = 1'b0;
                sink_hold  = $urandom_range(1, 3);
            end else begin
                sink_level = 1'b0;
                sink_hold  = $urandom_range(10, 40);
            end
        end
        sink_hold--;
        m_axis_tready <= sink_level;
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bus_replies.size() == 0) begin
                $error("reply with no item outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = bus_replies.pop_front();
                check_field("read_data", want.rdata, m_axis_tdata[OUT_RDATA_LSB +: 64]);
                check_field("fault_code", want.fault, m_axis_tdata[OUT_FAULT_LSB +: 2]);
                check_field("irq_line", want.irq, m_axis_tdata[OUT_IRQ_BIT]);
                check_field("notify_due", want.notify, m_axis_tdata[OUT_NOTIFY_BIT]);
                check_field("queue_ready", want.ready, m_axis_tdata[OUT_READY_BIT]);
                check_field("desc_table_addr", want.desc, m_axis_tdata[OUT_DESC_LSB +: 64]);
                check_field("avail_ring_addr", want.avail, m_axis_tdata[OUT_AVAIL_LSB +: 64]);
                check_field("used_ring_addr", want.used, m_axis_tdata[OUT_USED_LSB +: 64]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        set_config({32'($urandom), 32'($urandom)}, $urandom);
        test_access_faults();
        test_queue_bringup();
        set_config(64'd0, '1);
        test_random_traffic(500);
        set_config('1, 32'd0);
        test_random_traffic(500);
        set_config({32'($urandom), 32'($urandom)}, $urandom);
        test_random_traffic(450);
        set_config({32'($urandom), 32'($urandom)}, $urandom);
        test_random_traffic(500);
        wait_for_replies();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
